// ----- hw/rtl/png_chunk_stream_checker_macros.svh -----
// Assertion macros for the PNG chunk stream checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PNG_CHUNK_STREAM_CHECKER_MACROS_SVH
`define PNG_CHUNK_STREAM_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("png chunk stream checker: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("png chunk stream checker: assertion failed");

`endif

// ----- hw/rtl/pcsc_pkg.sv -----
// Shared types, constants and functions of the PNG chunk stream checker.
// No dependencies; used by every module of the block.
package pcsc_pkg;

    localparam int unsigned QueueDepth   = 4;
    localparam int unsigned OutDataWidth = 144;
    localparam int unsigned OutUserWidth = 2;

    localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;
    localparam logic [31:0] TypeIend = 32'h4945_4E44;

    localparam logic [7:0] SigBytes [0:7] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic [31:0] KnownTypes [0:20] = '{
        32'h4948_4452, 32'h504C_5445, 32'h4944_4154, 32'h4945_4E44, 32'h624B_4744,
        32'h6348_524D, 32'h6453_4947, 32'h6558_4946, 32'h6741_4D41, 32'h6849_5354,
        32'h6943_4350, 32'h6954_5874, 32'h7048_5973, 32'h7342_4954, 32'h7350_4C54,
        32'h7352_4742, 32'h7354_4552, 32'h7445_5874, 32'h7449_4D45, 32'h7452_4E53,
        32'h7A54_5874
    };

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CHUNK   = 2'd1,
        KIND_ERROR   = 2'd2
    } pcsc_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SIGNATURE = 3'd1,
        ERR_CRC       = 3'd2,
        ERR_LENGTH    = 3'd3,
        ERR_TRUNCATED = 3'd4
    } pcsc_err_t;

    typedef struct packed {
        pcsc_kind_t  kind;
        logic [7:0]  payload;
        logic [31:0] type_raw;
        logic [30:0] length;
        pcsc_err_t   err;
        logic [31:0] stored_crc;
        logic [31:0] computed_crc;
    } pcsc_rec_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [4:0] type_code(input logic [31:0] raw);
        logic [4:0] code;
        code = 5'd0;
        for (int i = 0; i < 21; i++)
        begin
            if (KnownTypes[i] == raw)
            begin
                code = 5'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

// ----- hw/rtl/pcsc_front.sv -----
// Front part: accepts file bytes, tracks signature and chunk framing and runs the CRC.
// Emits one result record per byte that causes one. Depends on pcsc_pkg.
module pcsc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    output pcsc_pkg::pcsc_rec_t rec
);

    typedef enum logic [6:0] {
        PH_SIG  = 7'b0000001,
        PH_LEN  = 7'b0000010,
        PH_TYPE = 7'b0000100,
        PH_DATA = 7'b0001000,
        PH_CRC  = 7'b0010000,
        PH_DONE = 7'b0100000,
        PH_HALT = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [30:0] idx_reg, idx_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] trl_reg, trl_next;

    logic [30:0] idx_inc;
    logic [31:0] len_upd;
    logic [31:0] type_upd;
    logic [31:0] crc_upd;
    logic [31:0] trl_upd;
    logic        fail;
    pcsc_pkg::pcsc_err_t fail_code;

    assign idx_inc  = idx_reg + 31'd1;
    assign len_upd  = {len_reg[23:0], in_byte};
    assign type_upd = {type_reg[23:0], in_byte};
    assign trl_upd  = {trl_reg[23:0], in_byte};
    assign crc_upd  = pcsc_pkg::crc_byte(crc_reg, in_byte);

    always_comb
    begin
        phase_next       = phase_reg;
        idx_next         = idx_reg;
        len_next         = len_reg;
        type_next        = type_reg;
        crc_next         = crc_reg;
        trl_next         = trl_reg;
        push             = 1'b0;
        fail             = 1'b0;
        fail_code        = pcsc_pkg::ERR_NONE;
        rec.kind         = pcsc_pkg::KIND_CHUNK;
        rec.payload      = 8'h00;
        rec.type_raw     = type_reg;
        rec.length       = len_reg[30:0];
        rec.err          = pcsc_pkg::ERR_NONE;
        rec.stored_crc   = trl_reg;
        rec.computed_crc = ~crc_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_SIG:
                begin
                    if (in_byte != pcsc_pkg::SigBytes[idx_reg[2:0]])
                    begin
                        fail      = 1'b1;
                        fail_code = pcsc_pkg::ERR_SIGNATURE;
                    end
                    else
                    begin
                        if (idx_reg[2:0] == 3'd7)
                        begin
                            phase_next = PH_LEN;
                            idx_next   = '0;
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                        if (in_last)
                        begin
                            fail      = 1'b1;
                            fail_code = pcsc_pkg::ERR_TRUNCATED;
                        end
                    end
                end
                PH_LEN:
                begin
                    len_next   = len_upd;
                    rec.length = len_upd[30:0];
                    idx_next   = idx_inc;
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        if (len_upd[31])
                        begin
                            fail      = 1'b1;
                            fail_code = pcsc_pkg::ERR_LENGTH;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                            idx_next   = '0;
                        end
                    end
                    if (in_last && !fail)
                    begin
                        fail      = 1'b1;
                        fail_code = pcsc_pkg::ERR_TRUNCATED;
                    end
                end
                PH_TYPE:
                begin
                    type_next        = type_upd;
                    crc_next         = crc_upd;
                    rec.type_raw     = type_upd;
                    rec.computed_crc = ~crc_upd;
                    idx_next         = idx_inc;
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        phase_next = (len_reg != 32'd0) ? PH_DATA : PH_CRC;
                        idx_next   = '0;
                    end
                    if (in_last)
                    begin
                        fail      = 1'b1;
                        fail_code = pcsc_pkg::ERR_TRUNCATED;
                    end
                end
                PH_DATA:
                begin
                    crc_next         = crc_upd;
                    rec.computed_crc = ~crc_upd;
                    idx_next         = idx_inc;
                    if ({1'b0, idx_inc} >= len_reg)
                    begin
                        phase_next = PH_CRC;
                        idx_next   = '0;
                    end
                    if (in_last)
                    begin
                        fail      = 1'b1;
                        fail_code = pcsc_pkg::ERR_TRUNCATED;
                    end
                    else
                    begin
                        push             = 1'b1;
                        rec.kind         = pcsc_pkg::KIND_PAYLOAD;
                        rec.payload      = in_byte;
                        rec.type_raw     = '0;
                        rec.length       = '0;
                        rec.stored_crc   = '0;
                        rec.computed_crc = '0;
                    end
                end
                PH_CRC:
                begin
                    trl_next       = trl_upd;
                    rec.stored_crc = trl_upd;
                    idx_next       = idx_inc;
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        if (trl_upd != ~crc_reg)
                        begin
                            fail      = 1'b1;
                            fail_code = pcsc_pkg::ERR_CRC;
                        end
                        else
                        begin
                            push = 1'b1;
                            if (type_reg == pcsc_pkg::TypeIend || in_last)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_LEN;
                                idx_next   = '0;
                                len_next   = '0;
                                type_next  = '0;
                                crc_next   = pcsc_pkg::CrcInit;
                                trl_next   = '0;
                            end
                        end
                    end
                    else if (in_last)
                    begin
                        fail      = 1'b1;
                        fail_code = pcsc_pkg::ERR_TRUNCATED;
                    end
                end
                default:
                begin
                end
            endcase
            if (fail)
            begin
                push       = 1'b1;
                rec.kind   = pcsc_pkg::KIND_ERROR;
                rec.err    = fail_code;
                phase_next = PH_HALT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            idx_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            crc_reg   <= pcsc_pkg::CrcInit;
            trl_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            crc_reg   <= crc_next;
            trl_reg   <= trl_next;
        end
    end

endmodule

// ----- hw/rtl/pcsc_queue.sv -----
// Short result queue between the front and back parts.
// Depends on pcsc_pkg for the record type.
module pcsc_queue #(
    parameter int unsigned DEPTH = pcsc_pkg::QueueDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcsc_pkg::pcsc_rec_t push_rec,
    output logic                full,
    output logic                not_empty,
    input  logic                pop,
    output pcsc_pkg::pcsc_rec_t head_rec
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);

    pcsc_pkg::pcsc_rec_t entry_reg [0:DEPTH-1];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;

    assign full      = (count_reg == CntWidth'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_rec  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ----- hw/rtl/pcsc_back.sv -----
// Back part: decodes the chunk type, forms the result item and holds it in the output register.
// Depends on pcsc_pkg.
module pcsc_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rec_valid,
    input  pcsc_pkg::pcsc_rec_t                   rec,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pcsc_pkg::OutDataWidth-1:0]     out_data,
    output logic [pcsc_pkg::OutUserWidth-1:0]     out_user
);

    logic                              valid_reg, valid_next;
    logic [pcsc_pkg::OutDataWidth-1:0] data_reg, data_next;
    logic [pcsc_pkg::OutUserWidth-1:0] user_reg, user_next;
    logic [4:0]                        code;
    logic                              fin;

    assign pop = rec_valid && (!valid_reg || out_ready);

    always_comb
    begin
        code = (rec.kind == pcsc_pkg::KIND_PAYLOAD) ? 5'd0 : pcsc_pkg::type_code(rec.type_raw);
        fin  = (rec.kind == pcsc_pkg::KIND_CHUNK) && (rec.type_raw == pcsc_pkg::TypeIend);
        data_next = {rec.computed_crc, rec.stored_crc, rec.err, fin, rec.length,
                     rec.type_raw, code, rec.payload};
        user_next = rec.kind;
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule

// ----- hw/rtl/png_chunk_stream_checker.sv -----
// Top level of the PNG chunk stream checker: front parser, result queue and output stage.
// Depends on pcsc_pkg, pcsc_front, pcsc_queue and pcsc_back.
//
// Channel   Direction  Content
// s_axis    in         tdata[7:0] data_byte, tlast last_byte
// m_axis    out        tuser out_kind, tdata packed result fields
//
// One byte is accepted per cycle while the queue is not full; the CRC update and
// field capture complete in that cycle. Results pass the queue, then the output register.
// The queue holds QUEUE_DEPTH results; input stalls only while it is full.
// Reset clears the parser to the signature phase and empties the queue.
module png_chunk_stream_checker #(
    parameter int unsigned QUEUE_DEPTH = pcsc_pkg::QueueDepth
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // data_byte [7:0]
    input  logic [7:0]                            s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // payload_byte [7:0], chunk_type_code [12:8], chunk_type_raw [44:13],
    // chunk_length [75:45], is_final_chunk [76], error_code [79:77],
    // stored_crc [111:80], computed_crc [143:112]
    output logic [pcsc_pkg::OutDataWidth-1:0]     m_axis_tdata,
    // out_kind [1:0]
    output logic [pcsc_pkg::OutUserWidth-1:0]     m_axis_tuser
);

    logic                accept;
    logic                push;
    logic                full;
    logic                not_empty;
    logic                pop;
    pcsc_pkg::pcsc_rec_t push_rec;
    pcsc_pkg::pcsc_rec_t head_rec;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pcsc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .in_last (s_axis_tlast),
        .push    (push),
        .rec     (push_rec)
    );

    pcsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (full),
        .not_empty (not_empty),
        .pop       (pop),
        .head_rec  (head_rec)
    );

    pcsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (not_empty),
        .rec       (head_rec),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

// ----- hw/rtl/pcsc_checker.sv -----
// Port-level assertions for the PNG chunk stream checker, bound to the top level.
// Depends on pcsc_pkg and png_chunk_stream_checker_macros.svh.
`include "png_chunk_stream_checker_macros.svh"

module pcsc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [7:0]                        s_axis_tdata,
    input logic                              s_axis_tlast,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pcsc_pkg::OutDataWidth-1:0] m_axis_tdata,
    input logic [pcsc_pkg::OutUserWidth-1:0] m_axis_tuser
);

    `PCSC_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `PCSC_ASSERT_NOW(payload_clean, m_axis_tvalid && m_axis_tuser == pcsc_pkg::KIND_PAYLOAD, m_axis_tdata[143:8] == '0)

    `PCSC_ASSERT_NOW(chunk_crc_match, m_axis_tvalid && m_axis_tuser == pcsc_pkg::KIND_CHUNK, m_axis_tdata[79:77] == pcsc_pkg::ERR_NONE && m_axis_tdata[111:80] == m_axis_tdata[143:112] && m_axis_tdata[7:0] == 8'h00)

    `PCSC_ASSERT_NOW(error_report_form, m_axis_tvalid && m_axis_tuser == pcsc_pkg::KIND_ERROR, m_axis_tdata[79:77] != pcsc_pkg::ERR_NONE && !m_axis_tdata[76] && m_axis_tdata[7:0] == 8'h00)

endmodule

bind png_chunk_stream_checker pcsc_checker u_checker (.*);
